// File: design/mrtu_pkg.sv
`default_nettype none
package mrtu_pkg;

  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_GEN = 16'hA001;
  localparam logic [7:0] SLAVE_ID_RESET = 8'h01;
  localparam int HEAD_LEN = 6;
  localparam logic [2:0] LAST_IDX = 3'd7;
  localparam logic [2:0] CRC_LO_IDX = 3'd6;
  localparam logic [2:0] CRC_HI_IDX = 3'd7;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] func;
    logic [15:0] reg_address;
    logic [15:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic last_byte;
  } out_item_t;

  typedef struct packed {
    logic [HEAD_LEN-1:0][7:0] head;
    logic [15:0] crc;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_GEN) : (acc >> 1);
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

// File: design/modbus_rtu_request_framer_unit.sv
// channel | direction | handshake         | beat
// in_     | input     | in_valid/in_stall   | in_item_t: func, reg_address, data_word
// out_    | output    | out_valid/out_stall | out_item_t: frame_byte, last_byte
// cfg_    | input     | cfg_valid/cfg_ready | slave_id byte, cfg_ready always high
// One request gives eight out beats; the byte serializer limits sustained throughput,
// emitting one beat a cycle while out is not stalled.
// The front handles a request in steps: capture, then CRC over the six head bytes, one byte a cycle.
// With the queue empty, a request passes the front, the queue memory and the back's frame register.
// Synchronous active-low reset clears control state; slave_id resets to 1.
// in_stall stays high after each accept while the CRC runs, and longer while the queue is full.
`default_nettype none
module modbus_rtu_request_framer_unit #(
  parameter int QUEUE_DEPTH = mrtu_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mrtu_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mrtu_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [7:0]          cfg_data
);

  logic [7:0] slave_id_r;
  logic push;
  mrtu_pkg::frame_t push_data;
  logic pop;
  logic q_valid;
  mrtu_pkg::frame_t q_data;
  mrtu_pkg::q_status_t q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_id_r <= mrtu_pkg::SLAVE_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slave_id_r <= cfg_data;
    end
  end

  mrtu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .slave_id  (slave_id_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  mrtu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_status  (q_status)
  );

  mrtu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: design/mrtu_front.sv
`default_nettype none
module mrtu_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [7:0]          slave_id,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mrtu_pkg::in_item_t  in_data,
  input  wire mrtu_pkg::q_status_t q_status,
  output logic                     push,
  output mrtu_pkg::frame_t         push_data
);

  localparam logic [2:0] CNT_DONE = 3'(mrtu_pkg::HEAD_LEN);

  logic busy_r;
  logic [2:0] cnt_r;
  logic [mrtu_pkg::HEAD_LEN-1:0][7:0] head_r;
  logic [15:0] crc_r;
  logic done;
  logic accept;

  assign done = busy_r && (cnt_r == CNT_DONE);
  assign push = done && !q_status.full;
  assign in_stall = busy_r && !push;
  assign accept = in_valid && !in_stall;
  assign push_data.head = head_r;
  assign push_data.crc = crc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= 3'd0;
    end else if (accept) begin
      busy_r <= 1'b1;
      cnt_r <= 3'd0;
    end else if (push) begin
      busy_r <= 1'b0;
    end else if (busy_r && !done) begin
      cnt_r <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_r[0] <= slave_id;
      head_r[1] <= in_data.func;
      head_r[2] <= in_data.reg_address[15:8];
      head_r[3] <= in_data.reg_address[7:0];
      head_r[4] <= in_data.data_word[15:8];
      head_r[5] <= in_data.data_word[7:0];
      crc_r <= mrtu_pkg::CRC_SEED;
    end else if (busy_r && !done) begin
      crc_r <= mrtu_pkg::crc_byte(crc_r, head_r[cnt_r]);
    end
  end

endmodule
`default_nettype wire

// File: design/mrtu_queue.sv
`default_nettype none
module mrtu_queue #(
  parameter int DEPTH = mrtu_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire mrtu_pkg::frame_t push_data,
  input  wire logic             pop,
  output logic                  q_valid,
  output mrtu_pkg::frame_t      q_data,
  output mrtu_pkg::q_status_t   q_status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  mrtu_pkg::frame_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign q_status.full = (count_r == CNT_FULL);
  assign q_status.empty = (count_r == '0);
  assign q_valid = !q_status.empty;
  assign q_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count did not advance on push");

endmodule
`default_nettype wire

// File: design/mrtu_back.sv
`default_nettype none
module mrtu_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire mrtu_pkg::frame_t q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output mrtu_pkg::out_item_t   out_data
);

  mrtu_pkg::frame_t frame_r;
  logic sending_r;
  logic [2:0] idx_r;
  logic out_valid_r;
  mrtu_pkg::out_item_t out_data_r;
  logic load;
  logic [7:0] cur_byte;

  assign load = sending_r && (!out_valid_r || !out_stall);
  assign pop = q_valid && (!sending_r || (load && idx_r == mrtu_pkg::LAST_IDX));
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    case (idx_r)
      mrtu_pkg::CRC_LO_IDX: cur_byte = frame_r.crc[7:0];
      mrtu_pkg::CRC_HI_IDX: cur_byte = frame_r.crc[15:8];
      default:              cur_byte = frame_r.head[idx_r];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r <= 1'b0;
      idx_r <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        sending_r <= 1'b1;
        idx_r <= 3'd0;
      end else if (load) begin
        idx_r <= idx_r + 3'd1;
        if (idx_r == mrtu_pkg::LAST_IDX) begin
          sending_r <= 1'b0;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frame_r <= q_data;
    end
    if (load) begin
      out_data_r.frame_byte <= cur_byte;
      out_data_r.last_byte <= (idx_r == mrtu_pkg::LAST_IDX);
    end
  end

endmodule
`default_nettype wire
